[sv/ppt_pkg.sv]
package ppt_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned StepW = $clog2(CordicSteps + 1);

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] PiQ28 = 34'sd843314857;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic signed [33:0] TwoPiQ28 = 34'sd1686629713;
  localparam logic signed [33:0] Q30One = 34'sd1073741824;
  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    KIND_POSE   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_VERTEX = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CORDIC,
    BK_MUL,
    BK_SUM
  } back_state_e;

  // one classified word between the front and back parts
  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic [30:0]        radius;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_nx;
    logic signed [31:0] world_ny;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic               box_valid;
  } res_t;

  function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
    case (i)
      5'd0: atan_q28 = 34'sd210828714;
      5'd1: atan_q28 = 34'sd124459457;
      5'd2: atan_q28 = 34'sd65760959;
      5'd3: atan_q28 = 34'sd33381290;
      5'd4: atan_q28 = 34'sd16755422;
      5'd5: atan_q28 = 34'sd8385879;
      5'd6: atan_q28 = 34'sd4193963;
      5'd7: atan_q28 = 34'sd2097109;
      5'd8: atan_q28 = 34'sd1048571;
      5'd9: atan_q28 = 34'sd524287;
      5'd29: atan_q28 = 34'sd0;
      default: atan_q28 = 34'sd1 <<< (5'd28 - i);
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = SatMax;
    else if (v < -66'sd2147483648) sat32 = SatMin;
    else sat32 = v[31:0];
  endfunction

endpackage

[sv/ppt_front.sv]
// accepts input words, drops unused kinds, queues commands for the back part
module ppt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppt_pkg::cmd_t in_cmd_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output ppt_pkg::cmd_t q_cmd_o
);

  ppt_pkg::cmd_t mem_q [ppt_pkg::QueueDepth];
  logic [ppt_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [ppt_pkg::QueuePtrW:0] cnt_q, cnt_d;
  logic push, pop;

  // classify: kind three is accepted and dropped
  assign in_ready_o = (cnt_q != ppt_pkg::QueuePtrW'(0) + (ppt_pkg::QueuePtrW+1)'(ppt_pkg::QueueDepth));
  assign push = in_valid_i && in_ready_o && (in_cmd_i.kind != ppt_pkg::KIND_NONE);
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_cmd_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (ppt_pkg::QueuePtrW+1)'(ppt_pkg::QueueDepth))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !push) else $error("push into full queue");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop count");

endmodule

[sv/ppt_back.sv]
// executes commands: cordic for poses, box for circles, rotation for vertices
module ppt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  ppt_pkg::cmd_t q_cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output ppt_pkg::res_t res_o
);

  ppt_pkg::back_state_e state_q, state_d;
  ppt_pkg::cmd_t cmd_q;
  logic signed [31:0] cos_q, sin_q, px_q, py_q;
  logic signed [31:0] mnx_q, mny_q, mxx_q, mxy_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic neg_q;
  logic [ppt_pkg::StepW-1:0] step_q;
  logic signed [63:0] p_q [8];
  logic res_valid_q;
  ppt_pkg::res_t res_q;

  logic accept;
  logic out_free;
  logic signed [33:0] z0, z1, shx, shy, atn, fx, fy;
  logic zneg;
  logic signed [65:0] sx, sy, snx, sny;
  logic signed [31:0] wx, wy, wnx, wny;
  logic signed [32:0] r33;
  ppt_pkg::res_t circ_res;

  assign out_free = !res_valid_q || res_ready_i;
  assign q_ready_o = (state_q == ppt_pkg::BK_IDLE) && out_free;
  assign accept = q_valid_i && q_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  // angle range reduction
  always_comb begin
    z0 = 34'(signed'(q_cmd_i.a2));
    if (z0 > ppt_pkg::PiQ28) z0 = z0 - ppt_pkg::TwoPiQ28;
    else if (z0 < -ppt_pkg::PiQ28) z0 = z0 + ppt_pkg::TwoPiQ28;
    zneg = 1'b0;
    z1 = z0;
    if (z0 > ppt_pkg::HalfPiQ28) begin
      z1 = z0 - ppt_pkg::PiQ28;
      zneg = 1'b1;
    end else if (z0 < -ppt_pkg::HalfPiQ28) begin
      z1 = z0 + ppt_pkg::PiQ28;
      zneg = 1'b1;
    end
  end

  // one cordic step and final clamp
  assign shx = cx_q >>> step_q;
  assign shy = cy_q >>> step_q;
  assign atn = ppt_pkg::atan_q28(5'(step_q));
  always_comb begin
    fx = cx_q;
    fy = cy_q;
    if (fx > ppt_pkg::Q30One) fx = ppt_pkg::Q30One;
    if (fx < -ppt_pkg::Q30One) fx = -ppt_pkg::Q30One;
    if (fy > ppt_pkg::Q30One) fy = ppt_pkg::Q30One;
    if (fy < -ppt_pkg::Q30One) fy = -ppt_pkg::Q30One;
    if (neg_q) begin
      fx = -fx;
      fy = -fy;
    end
  end

  // sums of registered products, rounded and saturated
  assign sx = 66'(p_q[0]) - 66'(p_q[1]) + 66'sd536870912;
  assign sy = 66'(p_q[2]) + 66'(p_q[3]) + 66'sd536870912;
  assign snx = 66'(p_q[4]) - 66'(p_q[5]) + 66'sd536870912;
  assign sny = 66'(p_q[6]) + 66'(p_q[7]) + 66'sd536870912;
  assign wx = ppt_pkg::sat32((sx >>> 30) + 66'(px_q));
  assign wy = ppt_pkg::sat32((sy >>> 30) + 66'(py_q));
  assign wnx = ppt_pkg::sat32(snx >>> 30);
  assign wny = ppt_pkg::sat32(sny >>> 30);
  assign r33 = 33'({2'b0, q_cmd_i.radius});

  // circle word: box around the stored position
  always_comb begin
    circ_res = '0;
    circ_res.box_min_x = ppt_pkg::sat32(66'(px_q) - 66'(r33));
    circ_res.box_min_y = ppt_pkg::sat32(66'(py_q) - 66'(r33));
    circ_res.box_max_x = ppt_pkg::sat32(66'(px_q) + 66'(r33));
    circ_res.box_max_y = ppt_pkg::sat32(66'(py_q) + 66'(r33));
    circ_res.box_valid = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppt_pkg::BK_IDLE: begin
        if (accept && q_cmd_i.kind == ppt_pkg::KIND_POSE) state_d = ppt_pkg::BK_CORDIC;
        else if (accept && q_cmd_i.kind == ppt_pkg::KIND_VERTEX) state_d = ppt_pkg::BK_MUL;
      end
      ppt_pkg::BK_CORDIC: begin
        if (step_q == ppt_pkg::StepW'(ppt_pkg::CordicSteps)) state_d = ppt_pkg::BK_IDLE;
      end
      ppt_pkg::BK_MUL: state_d = ppt_pkg::BK_SUM;
      ppt_pkg::BK_SUM: begin
        if (out_free) state_d = ppt_pkg::BK_IDLE;
      end
      default: state_d = ppt_pkg::BK_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppt_pkg::BK_IDLE;
      res_valid_q <= 1'b0;
      cos_q <= 32'sd1073741824;
      sin_q <= '0;
      px_q <= '0;
      py_q <= '0;
      mnx_q <= ppt_pkg::SatMax;
      mny_q <= ppt_pkg::SatMax;
      mxx_q <= ppt_pkg::SatMin;
      mxy_q <= ppt_pkg::SatMin;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      if ((accept && q_cmd_i.kind == ppt_pkg::KIND_CIRCLE) ||
          (state_q == ppt_pkg::BK_SUM && out_free)) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (accept && q_cmd_i.kind == ppt_pkg::KIND_POSE) begin
        px_q <= q_cmd_i.a0;
        py_q <= q_cmd_i.a1;
        step_q <= '0;
      end
      if (state_q == ppt_pkg::BK_CORDIC) begin
        if (step_q == ppt_pkg::StepW'(ppt_pkg::CordicSteps)) begin
          cos_q <= fx[31:0];
          sin_q <= fy[31:0];
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (state_q == ppt_pkg::BK_SUM && out_free) begin
        if (cmd_q.last) begin
          mnx_q <= ppt_pkg::SatMax;
          mny_q <= ppt_pkg::SatMax;
          mxx_q <= ppt_pkg::SatMin;
          mxy_q <= ppt_pkg::SatMin;
        end else begin
          if (wx < mnx_q) mnx_q <= wx;
          if (wy < mny_q) mny_q <= wy;
          if (wx > mxx_q) mxx_q <= wx;
          if (wy > mxy_q) mxy_q <= wy;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= q_cmd_i;
    if (accept && q_cmd_i.kind == ppt_pkg::KIND_POSE) begin
      cx_q <= ppt_pkg::CordicGain;
      cy_q <= '0;
      cz_q <= z1;
      neg_q <= zneg;
    end
    if (state_q == ppt_pkg::BK_CORDIC && step_q != ppt_pkg::StepW'(ppt_pkg::CordicSteps)) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - shy;
        cy_q <= cy_q + shx;
        cz_q <= cz_q - atn;
      end else begin
        cx_q <= cx_q + shy;
        cy_q <= cy_q - shx;
        cz_q <= cz_q + atn;
      end
    end
    if (state_q == ppt_pkg::BK_MUL) begin
      p_q[0] <= cmd_q.a0 * cos_q;
      p_q[1] <= cmd_q.a1 * sin_q;
      p_q[2] <= cmd_q.a0 * sin_q;
      p_q[3] <= cmd_q.a1 * cos_q;
      p_q[4] <= cmd_q.a2 * cos_q;
      p_q[5] <= cmd_q.a3 * sin_q;
      p_q[6] <= cmd_q.a2 * sin_q;
      p_q[7] <= cmd_q.a3 * cos_q;
    end
    if (accept && q_cmd_i.kind == ppt_pkg::KIND_CIRCLE) begin
      res_q <= circ_res;
    end
    if (state_q == ppt_pkg::BK_SUM && out_free) begin
      res_q.world_x <= wx;
      res_q.world_y <= wy;
      res_q.world_nx <= wnx;
      res_q.world_ny <= wny;
      res_q.box_valid <= cmd_q.last;
      res_q.box_min_x <= cmd_q.last ? ((wx < mnx_q) ? wx : mnx_q) : '0;
      res_q.box_min_y <= cmd_q.last ? ((wy < mny_q) ? wy : mny_q) : '0;
      res_q.box_max_x <= cmd_q.last ? ((wx > mxx_q) ? wx : mxx_q) : '0;
      res_q.box_max_y <= cmd_q.last ? ((wy > mxy_q) ? wy : mxy_q) : '0;
    end
  end

  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == ppt_pkg::BK_IDLE) else $error("accept while busy");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= ppt_pkg::StepW'(ppt_pkg::CordicSteps)) else $error("cordic step range");
  a_sum_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppt_pkg::BK_SUM && out_free) |=> res_valid_q) else $error("lost result");
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> res_valid_q && $stable(res_q)) else $error("result changed");

endmodule

[sv/polygon_pose_transform_bounds.sv]
// Rigid 2D transform of shape geometry with a running bounding box.
// Input channel s_axis: tuser = kind (0 pose, 1 circle, 2 vertex, 3 ignored),
// tlast marks the last vertex of a polygon, tdata carries the other fields.
// Output channel m_axis: tlast = box_valid, tdata the transformed vertex,
// normal and box. Poses give no word; circles and vertices give one each.
// Words pass a two-entry queue into a back part that handles one at a time.
// From the queue head, a circle goes straight to the output register; a vertex
// passes the multiply stage, the sum stage and the output register; a pose runs
// CordicSteps iterations of the cordic iteration registers, with no output.
// Sustained rate: circles one per cycle while m_axis_tready stays high; the
// single multiply stage and cordic unit take no new word until they finish.
// Reset gives cos 1, sin 0, position 0 and an empty running box.
// When the receiver stalls the output register holds its word; the back
// part stops at that word and the queue then fills and drops s_axis_tready.
module polygon_pose_transform_bounds (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, angle, radius, vert_x, vert_y, norm_x, norm_y, 1 pad bit
  input  logic [255:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // world_x, world_y, world_nx, world_ny, box_min_x, box_min_y, box_max_x,
  // box_max_y
  output logic [255:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  ppt_pkg::cmd_t in_cmd, q_cmd;
  ppt_pkg::res_t res;
  logic q_valid, q_ready;

  // pack by kind: vertex fields go to the same slots as pose fields
  always_comb begin
    in_cmd.kind = ppt_pkg::kind_e'(s_axis_tuser);
    in_cmd.radius = s_axis_tdata[126:96];
    in_cmd.last = s_axis_tlast;
    if (s_axis_tuser == ppt_pkg::KIND_VERTEX) begin
      in_cmd.a0 = s_axis_tdata[158:127];
      in_cmd.a1 = s_axis_tdata[190:159];
      in_cmd.a2 = s_axis_tdata[222:191];
      in_cmd.a3 = s_axis_tdata[254:223];
    end else begin
      in_cmd.a0 = s_axis_tdata[31:0];
      in_cmd.a1 = s_axis_tdata[63:32];
      in_cmd.a2 = s_axis_tdata[95:64];
      in_cmd.a3 = '0;
    end
  end

  ppt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  ppt_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {res.box_max_y, res.box_max_x, res.box_min_y, res.box_min_x,
                         res.world_ny, res.world_nx, res.world_y, res.world_x};
  assign m_axis_tlast = res.box_valid;

endmodule

[tb/ppt_checker.sv]
module ppt_checker
  import ppt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [255:0] s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         s_tlast_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [255:0] m_tdata_i,
  input  logic         m_tlast_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_Q28 [30] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
  };

  // body pose and running box as the block should hold them
  logic signed [31:0] cos_q, sin_q, body_x, body_y;
  logic signed [31:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;
  res_t shape_results [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = shape_results.size();

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return SatMax;
    if (v < -64'sd2147483648) return SatMin;
    return v[31:0];
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // rounded a*c - b*s back to the format of a
  function automatic longint rotate_term(longint a, longint b, longint c, longint s);
    return (a * c - b * s + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint sext32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  task automatic update_trig(longint z);
    longint x, y, nx;
    bit neg;
    x = CordicGain;
    y = 0;
    neg = 0;
    if (z > PiQ28) z -= TwoPiQ28;
    else if (z < -PiQ28) z += TwoPiQ28;
    if (z > HalfPiQ28) begin
      z -= PiQ28;
      neg = 1;
    end else if (z < -HalfPiQ28) begin
      z += PiQ28;
      neg = 1;
    end
    for (int i = 0; i < CordicSteps && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_Q28[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_Q28[i];
      end
      x = nx;
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    if (neg) begin
      x = -x;
      y = -y;
    end
    cos_q = x[31:0];
    sin_q = y[31:0];
  endtask

  task automatic clear_box();
    box_lo_x = SatMax;
    box_lo_y = SatMax;
    box_hi_x = SatMin;
    box_hi_y = SatMin;
  endtask

  // one input word: update state and queue the shape result it causes
  task automatic predict_shape(logic [1:0] kind, logic [255:0] d, logic last);
    res_t r;
    longint c, s, vx, vy, nx, ny, rad;
    logic signed [31:0] wx, wy;
    r = '0;
    c = cos_q;
    s = sin_q;
    case (kind_e'(kind))
      KIND_POSE: begin
        body_x = d[31:0];
        body_y = d[63:32];
        update_trig(sext32(d[95:64]));
      end
      KIND_CIRCLE: begin
        rad = longint'(d[126:96]);
        r.box_min_x = clip32(longint'(body_x) - rad);
        r.box_min_y = clip32(longint'(body_y) - rad);
        r.box_max_x = clip32(longint'(body_x) + rad);
        r.box_max_y = clip32(longint'(body_y) + rad);
        r.box_valid = 1'b1;
        shape_results.push_back(r);
      end
      KIND_VERTEX: begin
        vx = sext32(d[158:127]);
        vy = sext32(d[190:159]);
        nx = sext32(d[222:191]);
        ny = sext32(d[254:223]);
        wx = clip32(rotate_term(vx, vy, c, s) + longint'(body_x));
        wy = clip32(rotate_term(vx, -vy, s, c) + longint'(body_y));
        r.world_x  = wx;
        r.world_y  = wy;
        r.world_nx = clip32(rotate_term(nx, ny, c, s));
        r.world_ny = clip32(rotate_term(nx, -ny, s, c));
        if (wx < box_lo_x) box_lo_x = wx;
        if (wy < box_lo_y) box_lo_y = wy;
        if (wx > box_hi_x) box_hi_x = wx;
        if (wy > box_hi_y) box_hi_y = wy;
        if (last) begin
          r.box_min_x = box_lo_x;
          r.box_min_y = box_lo_y;
          r.box_max_x = box_hi_x;
          r.box_max_y = box_hi_y;
          r.box_valid = 1'b1;
          clear_box();
        end
        shape_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    fails++;
  endtask

  task automatic compare_word(res_t want);
    if (m_tdata_i[31:0] !== want.world_x)
      report_mismatch("world_x", m_tdata_i[31:0], want.world_x);
    if (m_tdata_i[63:32] !== want.world_y)
      report_mismatch("world_y", m_tdata_i[63:32], want.world_y);
    if (m_tdata_i[95:64] !== want.world_nx)
      report_mismatch("world_nx", m_tdata_i[95:64], want.world_nx);
    if (m_tdata_i[127:96] !== want.world_ny)
      report_mismatch("world_ny", m_tdata_i[127:96], want.world_ny);
    if (m_tdata_i[159:128] !== want.box_min_x)
      report_mismatch("box_min_x", m_tdata_i[159:128], want.box_min_x);
    if (m_tdata_i[191:160] !== want.box_min_y)
      report_mismatch("box_min_y", m_tdata_i[191:160], want.box_min_y);
    if (m_tdata_i[223:192] !== want.box_max_x)
      report_mismatch("box_max_x", m_tdata_i[223:192], want.box_max_x);
    if (m_tdata_i[255:224] !== want.box_max_y)
      report_mismatch("box_max_y", m_tdata_i[255:224], want.box_max_y);
    if (m_tlast_i !== want.box_valid)
      report_mismatch("box_valid", 32'(m_tlast_i), 32'(want.box_valid));
  endtask

  initial begin
    fails = 0;
    cos_q = Q30One[31:0];
    sin_q = '0;
    body_x = '0;
    body_y = '0;
    clear_box();
  end

  // watch both channels at each rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (shape_results.size() == 0) begin
          $display("unexpected output word at %0t", $realtime);
          fails++;
        end else begin
          compare_word(shape_results.pop_front());
        end
      end
      if (s_tvalid_i && s_tready_i) predict_shape(s_tuser_i, s_tdata_i, s_tlast_i);
    end
  end

endmodule

[tb/polygon_pose_transform_bounds_tb.sv]
module polygon_pose_transform_bounds_tb;
  import ppt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumWords   = 900;
  localparam int StallLimit = 5000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  logic         m_axis_tlast;

  int fail_count, pending;
  int sent_words = 0;
  int tx_idle_pct = 30;
  int rx_idle_pct = 65;
  bit hold_done = 0;
  bit stim_done = 0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  polygon_pose_transform_bounds dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  ppt_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tlast_i(m_axis_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [255:0] pack_word(
    logic [31:0] px, logic [31:0] py, logic [31:0] ang, logic [30:0] rad,
    logic [31:0] vx, logic [31:0] vy, logic [31:0] nx, logic [31:0] ny, logic pad
  );
    return {pad, ny, nx, vy, vx, rad, ang, py, px};
  endfunction

  // random word with noise in every field, the named ones set after
  function automatic logic [255:0] noise_word();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // coordinate: mostly modest, sometimes the whole range
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
  endfunction

  function automatic logic [31:0] rand_angle();
    if ($urandom_range(15) == 0) return $urandom;
    return 32'(longint'($urandom_range(0, 1686629714)) - 64'sd843314857);
  endfunction

  function automatic logic [31:0] rand_norm();
    if ($urandom_range(7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
  endfunction

  // offer one word, with a random gap first, and wait for acceptance
  task automatic put_word(kind_e kind, logic [255:0] d, logic last);
    if (tx_idle_pct > 0) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    sent_words++;
  endtask

  task automatic put_pose(logic [31:0] px, logic [31:0] py, logic [31:0] ang);
    logic [255:0] d;
    d = noise_word();
    d[31:0] = px;
    d[63:32] = py;
    d[95:64] = ang;
    put_word(KIND_POSE, d, $urandom_range(1));
  endtask

  task automatic put_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] nx,
                            logic [31:0] ny, logic last);
    logic [255:0] d;
    d = noise_word();
    d[158:127] = vx;
    d[190:159] = vy;
    d[222:191] = nx;
    d[254:223] = ny;
    put_word(KIND_VERTEX, d, last);
  endtask

  task automatic put_circle(logic [30:0] rad);
    logic [255:0] d;
    d = noise_word();
    d[126:96] = rad;
    put_word(KIND_CIRCLE, d, $urandom_range(1));
  endtask

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_words >= 300) begin
        hold_done = 1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else if (pending != 0 || !stim_done)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset pose, extremes, angle wraps, saturation, ignored kind
    put_vertex(32'h0001_0000, 32'h0002_0000, 32'h4000_0000, 32'h0, 1'b0);
    put_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    put_circle(31'h0);
    put_circle(31'h7fff_ffff);
    put_pose(32'h7fff_ffff, 32'h8000_0000, 32'd421657429);
    put_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h4000_0000, 32'h4000_0000, 1'b0);
    put_vertex(32'h8000_0000, 32'h8000_0000, 32'h0, 32'hc000_0000, 1'b1);
    put_circle(31'h7fff_ffff);
    put_pose(32'h8000_0000, 32'h7fff_ffff, 32'd843314858);
    put_vertex(32'h0010_0000, 32'h0, 32'h4000_0000, 32'h0, 1'b1);
    put_pose(32'h0, 32'h0, 32'hcdbc_1556);
    put_vertex(32'h0010_0000, 32'h0020_0000, 32'h4000_0000, 32'h0, 1'b1);
    put_pose(32'h0, 32'h0, 32'h7fff_ffff);
    put_vertex(32'h0003_0000, 32'hfffd_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    put_pose(32'h0, 32'h0, 32'h8000_0000);
    put_vertex(32'h0003_0000, 32'h0001_0000, 32'h0, 32'h4000_0000, 1'b1);
    put_pose(32'h0001_0000, 32'hffff_0000, 32'd843314857);
    put_vertex(32'h0, 32'h0, 32'h4000_0000, 32'h4000_0000, 1'b1);
    put_pose(32'h0, 32'h0, -32'sd421657428);
    put_vertex(32'h0005_0000, 32'h0005_0000, 32'hc000_0000, 32'h4000_0000, 1'b1);
    put_word(KIND_NONE, noise_word(), 1'b1);
    put_word(KIND_NONE, '1, 1'b0);
    put_pose(32'h0, 32'h0, 32'h0);

    // random: poses, polygons ending in last, circles, some noise
    while (sent_words < NumWords) begin
      if (sent_words >= NumWords / 3 && sent_words < 2 * NumWords / 3) begin
        tx_idle_pct = 65;
        rx_idle_pct = 30;
      end else if (sent_words >= 2 * NumWords / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: put_pose(rand_coord(), rand_coord(), rand_angle());
        1: put_circle($urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0100_0000)));
        2: put_word(kind_e'($urandom_range(3) == 0 ? KIND_NONE : KIND_VERTEX), noise_word(),
                    $urandom_range(1));
        default: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            put_vertex(rand_coord(), rand_coord(), rand_norm(), rand_norm(), i == n - 1);
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[polygon_pose_transform_bounds.f]
sv/ppt_pkg.sv
sv/ppt_front.sv
sv/ppt_back.sv
sv/polygon_pose_transform_bounds.sv
tb/ppt_checker.sv
tb/polygon_pose_transform_bounds_tb.sv
